@@ hw/rtl/lsbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared types and constants of the size-bounded LRU cache core.
// ----------------------------------------------------------------------------
package lsbc_pkg;

  localparam int DEF_ENTRIES = 64;

  localparam logic [6:0]  ENTRY_LIMIT_RESET = 7'd64;
  localparam logic [31:0] BYTE_LIMIT_RESET  = 32'd67108864;

  typedef logic [2:0] req_t;

  localparam req_t REQ_LOOKUP = 3'd0;
  localparam req_t REQ_INSERT = 3'd1;
  localparam req_t REQ_REMOVE = 3'd2;
  localparam req_t REQ_CLEAR  = 3'd3;
  localparam req_t REQ_EVICT  = 3'd4;

  localparam logic CFG_ENTRY_LIMIT = 1'b0;
  localparam logic CFG_BYTE_LIMIT  = 1'b1;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] id;
    logic [31:0] size;
    logic [31:0] stamp;
    logic [31:0] uses;
  } entry_t;

  typedef struct packed {
    logic load_req;
    logic scan_find;
    logic scan_min;
    logic apply_evict;
    logic apply_find;
    logic apply_clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic too_big;
    logic need_evict_ins;
    logic need_free;
    logic scan_done;
  } status_t;

endpackage

@@ hw/rtl/lru_size_bounded_cache_core.sv @@
// ----------------------------------------------------------------------------
// lru_size_bounded_cache_core
// Fully associative tag-to-id cache bounded by entry count and total bytes.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  request  | in_valid / in_stall   | req_type key_tag item_id item_bytes
//           |                       | free_target
//  result   | out_valid / out_stall | hit found_id accepted freed_bytes
//           |                       | entry_count bytes_used hits_total
//           |                       | misses_total
//  config   | cfg_wen               | cfg_index cfg_data
//
// Every entry scan walks the entry memory, one slot a cycle. Lookup and remove
// take one scan; each eviction adds a scan of its own. Clear and a refused
// insert need no scan. One request is in work at a time; a finished word waits
// in the output register while the next request is accepted. Reset is
// synchronous and needs no clearing pass.
module lru_size_bounded_cache_core #(
  parameter int ENTRIES = lsbc_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] key_tag,
  input  logic [31:0] item_id,
  input  logic [31:0] item_bytes,
  input  logic [31:0] free_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] found_id,
  output logic        accepted,
  output logic [31:0] freed_bytes,
  output logic [6:0]  entry_count,
  output logic [31:0] bytes_used,
  output logic [31:0] hits_total,
  output logic [31:0] misses_total
);
  import lsbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lsbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lsbc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .key_tag      (key_tag),
    .item_id      (item_id),
    .item_bytes   (item_bytes),
    .free_target  (free_target),
    .cmd          (cmd),
    .status       (status),
    .hit          (hit),
    .found_id     (found_id),
    .accepted     (accepted),
    .freed_bytes  (freed_bytes),
    .entry_count  (entry_count),
    .bytes_used   (bytes_used),
    .hits_total   (hits_total),
    .misses_total (misses_total)
  );

endmodule

@@ hw/rtl/lsbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsbc_ctrl
// Request sequencer: orders the scans, evictions and updates of one request.
// ----------------------------------------------------------------------------
module lsbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lsbc_pkg::status_t status,
  output lsbc_pkg::cmd_t    cmd
);
  import lsbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_MIN,
    S_APPLY_MIN,
    S_SCAN_FIND,
    S_APPLY_FIND,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        case (status.req) inside
          REQ_LOOKUP, REQ_REMOVE: begin
            cmd.scan_find = 1'b1;
            state_next    = S_SCAN_FIND;
          end
          REQ_INSERT: begin
            if (status.too_big) begin
              state_next = S_RESULT;
            end else if (status.need_evict_ins) begin
              cmd.scan_min = 1'b1;
              state_next   = S_SCAN_MIN;
            end else begin
              cmd.scan_find = 1'b1;
              state_next    = S_SCAN_FIND;
            end
          end
          REQ_CLEAR: begin
            cmd.apply_clear = 1'b1;
            state_next      = S_RESULT;
          end
          REQ_EVICT: begin
            if (status.need_free) begin
              cmd.scan_min = 1'b1;
              state_next   = S_SCAN_MIN;
            end else begin
              state_next = S_RESULT;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_SCAN_MIN: begin
        if (status.scan_done) state_next = S_APPLY_MIN;
      end
      S_APPLY_MIN: begin
        // After each eviction the limits are checked again.
        cmd.apply_evict = 1'b1;
        state_next      = S_CHECK;
      end
      S_SCAN_FIND: begin
        if (status.scan_done) state_next = S_APPLY_FIND;
      end
      S_APPLY_FIND: begin
        cmd.apply_find = 1'b1;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/lsbc_datapath.sv @@
// ----------------------------------------------------------------------------
// lsbc_datapath
// Entry memory, valid bits, scan engine, totals, counters and result word.
// ----------------------------------------------------------------------------
module lsbc_datapath #(
  parameter int ENTRIES = lsbc_pkg::DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        req_type,
  input  logic [31:0]       key_tag,
  input  logic [31:0]       item_id,
  input  logic [31:0]       item_bytes,
  input  logic [31:0]       free_target,
  input  lsbc_pkg::cmd_t    cmd,
  output lsbc_pkg::status_t status,
  output logic              hit,
  output logic [31:0]       found_id,
  output logic              accepted,
  output logic [31:0]       freed_bytes,
  output logic [6:0]        entry_count,
  output logic [31:0]       bytes_used,
  output logic [31:0]       hits_total,
  output logic [31:0]       misses_total
);
  import lsbc_pkg::*;

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

  entry_t mem [ENTRIES];

  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   count;
  logic [31:0]        byte_total;
  logic [31:0]        hit_counter;
  logic [31:0]        miss_counter;
  logic [31:0]        stamp_clock;
  logic [6:0]         entry_limit;
  logic [31:0]        byte_limit;

  req_t               req;
  logic [31:0]        key;
  logic [31:0]        id;
  logic [31:0]        bytes;
  logic [31:0]        target;

  logic               hit_f;
  logic               acc_f;
  logic [31:0]        found_f;
  logic [32:0]        freed;

  logic               issuing;
  logic [ADDR_W-1:0]  issue_addr;
  logic               rd_vld;
  logic [ADDR_W-1:0]  rd_idx;
  entry_t             rd_data;
  logic               scan_is_min;

  logic               found;
  logic [ADDR_W-1:0]  match_idx;
  entry_t             match_ent;
  logic               free_found;
  logic [ADDR_W-1:0]  free_idx;
  logic               best_found;
  logic [ADDR_W-1:0]  best_idx;
  entry_t             best_ent;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic               rd_valid_bit;
  logic               over_count;
  logic               over_bytes;

  assign rd_valid_bit = valid[rd_idx];
  assign over_count   = (CMP_W'(count) >= CMP_W'(entry_limit)) || (count == CNT_W'(ENTRIES));
  assign over_bytes   = ({1'b0, byte_total} + {1'b0, bytes}) > {1'b0, byte_limit};

  always_comb begin
    status.req            = req;
    status.too_big        = bytes > byte_limit;
    status.need_evict_ins = (count != '0) && (over_count || over_bytes);
    status.need_free      = (count != '0) && (freed < {1'b0, target});
    status.scan_done      = rd_vld && (rd_idx == LAST_ADDR);
  end

  // A hit rewrites its own slot; an insert reuses a slot holding the key or
  // takes the lowest free one.
  always_comb begin
    wr_en   = cmd.apply_find && ((req == REQ_LOOKUP && found) || req == REQ_INSERT);
    wr_addr = (req == REQ_INSERT && !found) ? free_idx : match_idx;
    if (req == REQ_INSERT) begin
      wr_data.tag   = key;
      wr_data.id    = id;
      wr_data.size  = bytes;
      wr_data.stamp = stamp_clock;
      wr_data.uses  = 32'd1;
    end else begin
      wr_data       = match_ent;
      wr_data.stamp = stamp_clock;
      wr_data.uses  = match_ent.uses + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[issue_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      count        <= '0;
      byte_total   <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      stamp_clock  <= '0;
      entry_limit  <= ENTRY_LIMIT_RESET;
      byte_limit   <= BYTE_LIMIT_RESET;
      issuing      <= 1'b0;
      rd_vld       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        if (cfg_index == CFG_ENTRY_LIMIT) entry_limit <= cfg_data[6:0];
        else byte_limit <= cfg_data;
      end

      if (cmd.load_req) begin
        req     <= req_type;
        key     <= key_tag;
        id      <= item_id;
        bytes   <= item_bytes;
        target  <= free_target;
        freed   <= '0;
        hit_f   <= 1'b0;
        acc_f   <= 1'b0;
        found_f <= '0;
      end

      // Scan engine: one address issued per cycle, its data examined in the next cycle.
      rd_vld <= issuing;
      rd_idx <= issue_addr;
      if (cmd.scan_find || cmd.scan_min) begin
        issuing     <= 1'b1;
        issue_addr  <= '0;
        scan_is_min <= cmd.scan_min;
        found       <= 1'b0;
        free_found  <= 1'b0;
        best_found  <= 1'b0;
      end else if (issuing) begin
        if (issue_addr == LAST_ADDR) issuing <= 1'b0;
        else issue_addr <= issue_addr + 1'b1;
      end

      if (rd_vld) begin
        if (scan_is_min) begin
          if (rd_valid_bit && (!best_found || rd_data.stamp < best_ent.stamp ||
              (rd_data.stamp == best_ent.stamp && rd_data.uses < best_ent.uses))) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_ent   <= rd_data;
          end
        end else begin
          if (rd_valid_bit && rd_data.tag == key && !found) begin
            found     <= 1'b1;
            match_idx <= rd_idx;
            match_ent <= rd_data;
          end
          if (!rd_valid_bit && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
        end
      end

      if (cmd.apply_evict) begin
        valid[best_idx] <= 1'b0;
        byte_total      <= byte_total - best_ent.size;
        count           <= count - 1'b1;
        // Only an evict request reports the bytes it released.
        if (req == REQ_EVICT) freed <= freed + {1'b0, best_ent.size};
      end

      if (cmd.apply_find) begin
        case (req)
          REQ_LOOKUP: begin
            if (found) begin
              hit_counter <= hit_counter + 32'd1;
              stamp_clock <= stamp_clock + 32'd1;
              hit_f       <= 1'b1;
              found_f     <= match_ent.id;
            end else begin
              miss_counter <= miss_counter + 32'd1;
            end
          end
          REQ_INSERT: begin
            acc_f       <= 1'b1;
            stamp_clock <= stamp_clock + 32'd1;
            valid[wr_addr] <= 1'b1;
            if (found) begin
              byte_total <= byte_total - match_ent.size + bytes;
            end else begin
              byte_total <= byte_total + bytes;
              count      <= count + 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (found) begin
              valid[match_idx] <= 1'b0;
              byte_total       <= byte_total - match_ent.size;
              count            <= count - 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.apply_clear) begin
        valid      <= '0;
        byte_total <= '0;
        count      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit          <= hit_f;
      found_id     <= found_f;
      accepted     <= acc_f;
      freed_bytes  <= freed[31:0];
      entry_count  <= 7'(count);
      bytes_used   <= byte_total;
      hits_total   <= hit_counter;
      misses_total <= miss_counter;
    end
  end

endmodule
